### rtl/core/bgbb_pkg.sv
// Shared types and constants for the background bounding box block.
// Used by bgbb_raster and background_bounding_box; no dependencies.
package bgbb_pkg;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int OUT_W   = 80;

	localparam logic [DIM_W-1:0]   MAX_DIM      = 13'd4096;
	localparam logic [COORD_W-1:0] COORD_MAX    = '1;
	localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_CORNERS = 2'd1,
		STAT_EMPTY   = 2'd2
	} status_t;

	// raster position of one pixel transaction
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               first;   // background reference pixel
		logic               corner;  // one of the three other corners
		logic               last;    // final pixel of the frame
	} raster_pos_t;

	// last index along one axis; zero is taken as one, above MAX_DIM as MAX_DIM
	function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] m;
		m = v - 13'd1;
		if (v == '0) begin
			return '0;
		end else if (v > MAX_DIM) begin
			return COORD_MAX;
		end else begin
			return m[COORD_W-1:0];
		end
	endfunction

endpackage

### rtl/core/bgbb_raster.sv
// Frame size registers and raster x/y counters.
// Depends on bgbb_pkg.
module bgbb_raster (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bgbb_pkg::DIM_W-1:0]  cfg_wdata,
	input  logic                        advance,
	output bgbb_pkg::raster_pos_t       pos
);
	import bgbb_pkg::*;

	logic [DIM_W-1:0]   fw_q, fh_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [COORD_W-1:0] w_last, h_last;
	logic               last_col, last_row;

	assign w_last   = dim_last(fw_q);
	assign h_last   = dim_last(fh_q);
	assign last_col = (x_q >= w_last);
	assign last_row = (y_q >= h_last);

	always_comb begin
		pos.x      = x_q;
		pos.y      = y_q;
		pos.first  = (x_q == '0) && (y_q == '0);
		pos.last   = last_col && last_row;
		pos.corner = !pos.first && ((last_col && (y_q == '0)) ||
			((x_q == '0) && last_row) || (last_col && last_row));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= WIDTH_RESET;
			fh_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_wdata;
				REG_FRAME_HEIGHT: fh_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// any register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_we) begin
			x_q <= '0;
			y_q <= '0;
		end else if (advance) begin
			if (last_col && last_row) begin
				x_q <= '0;
				y_q <= '0;
			end else if (last_col) begin
				x_q <= '0;
				y_q <= y_q + 12'd1;
			end else begin
				x_q <= x_q + 12'd1;
			end
		end
	end

endmodule

### rtl/core/background_bounding_box.sv
// Top level of the background bounding box (auto-crop) block.
// Depends on bgbb_pkg and bgbb_raster.
// One pixel transaction per clock, but for the stall described below.
// Pixels arrive in raster order, x fastest, rows from y = 0; the first
// pixel of a frame sets the background value. Each pixel is registered
// with its x/y position (stage 1), then one compare against the background
// and four min/max updates run on it and are committed when stage 1 drains;
// the result is then held in an output register. One result transaction
// comes out per frame, on the frame's last pixel. The result sits there;
// pixels keep flowing while it waits, and only the last pixel of the next
// frame stalls if it is still untaken.
// Status: ok, corners differ (takes priority), or no foreground; on
// either error every other field is zero. A register write abandons the
// frame in progress and holds off the pixel input in its cycle; write only
// while the block is idle. Frame sizes of zero act as one, above 4096 as 4096.
module background_bounding_box (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port: index 0 frame_width, 1 frame_height
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [bgbb_pkg::DIM_W-1:0]     cfg_wdata,
	// pixel stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] pixel
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [11:0] min_x, [23:12] min_y, [35:24] max_x, [47:36] max_y,
	// [60:48] crop_width, [73:61] crop_height, [75:74] pad_bytes,
	// [77:76] status, [79:78] zero
	output logic [bgbb_pkg::OUT_W-1:0]     m_tdata
);
	import bgbb_pkg::*;

	raster_pos_t        pos;
	logic               in_acc;
	logic               s1_go;

	logic               s1_valid_q;
	raster_pos_t        s1_pos;
	logic [PIX_W-1:0]   s1_pix;

	logic [PIX_W-1:0]   bg_q;
	logic [COORD_W-1:0] left_q, right_q, bottom_q, top_q;
	logic               found_q, corners_q;

	logic               fg;
	logic [COORD_W-1:0] left_n, right_n, bottom_n, top_n;
	logic               found_n, corners_n;
	logic [DIM_W-1:0]   cw, ch;

	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;
	logic [OUT_W-1:0]   result;

	bgbb_raster u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.advance   (in_acc),
		.pos       (pos)
	);

	// stage 1 drains unless it holds a last pixel and the result is blocked
	assign s1_go    = s1_valid_q && (!s1_pos.last || !out_valid_q || m_tready);
	assign s_tready = (!s1_valid_q || s1_go) && !cfg_we;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cfg_we) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_pos <= pos;
			s1_pix <= s_tdata;
		end
	end

	// box update for the pixel in stage 1
	always_comb begin
		fg        = !s1_pos.first && (s1_pix != bg_q);
		left_n    = left_q;
		right_n   = right_q;
		bottom_n  = bottom_q;
		top_n     = top_q;
		found_n   = found_q;
		corners_n = corners_q;
		if (fg) begin
			if (s1_pos.x < left_q)   left_n   = s1_pos.x;
			if (s1_pos.x > right_q)  right_n  = s1_pos.x;
			if (s1_pos.y < bottom_q) bottom_n = s1_pos.y;
			if (s1_pos.y > top_q)    top_n    = s1_pos.y;
			found_n = 1'b1;
			if (s1_pos.corner) corners_n = 1'b0;
		end
	end

	assign cw = {1'b0, right_n} - {1'b0, left_n} + 13'd1;
	assign ch = {1'b0, top_n} - {1'b0, bottom_n} + 13'd1;

	always_comb begin
		if (!corners_n) begin
			result = {2'b00, STAT_CORNERS, {(OUT_W-4){1'b0}}};
		end else if (!found_n) begin
			result = {2'b00, STAT_EMPTY, {(OUT_W-4){1'b0}}};
		end else begin
			result = {2'b00, STAT_OK, cw[1:0], ch, cw, top_n, right_n, bottom_n, left_n};
		end
	end

	// frame accumulators; cleared after each result and on register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q      <= '0;
			left_q    <= COORD_MAX;
			right_q   <= '0;
			bottom_q  <= COORD_MAX;
			top_q     <= '0;
			found_q   <= 1'b0;
			corners_q <= 1'b1;
		end else if (cfg_we || (s1_go && s1_pos.last)) begin
			bg_q      <= '0;
			left_q    <= COORD_MAX;
			right_q   <= '0;
			bottom_q  <= COORD_MAX;
			top_q     <= '0;
			found_q   <= 1'b0;
			corners_q <= 1'b1;
		end else if (s1_go) begin
			if (s1_pos.first) bg_q <= s1_pix;
			left_q    <= left_n;
			right_q   <= right_n;
			bottom_q  <= bottom_n;
			top_q     <= top_n;
			found_q   <= found_n;
			corners_q <= corners_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_pos.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_pos.last) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
